>>> rtl/heart_rate_averager_alert_core_assert.svh
// ----------------------------------------------------------------------------
// heart rate averager assertion macros
// shared macro forms for the concurrent checks on the core ports
// ----------------------------------------------------------------------------
`ifndef HEART_RATE_AVERAGER_ALERT_CORE_ASSERT_SVH
`define HEART_RATE_AVERAGER_ALERT_CORE_ASSERT_SVH

// property checked on every edge outside reset
`define HRA_ASSERT(label, prop, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error(msg);

// antecedent on one edge, consequent on the next
`define HRA_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

>>> rtl/hra_pkg.sv
// ----------------------------------------------------------------------------
// hra_pkg
// shared widths, codes and types of the pulse rate averager
// ----------------------------------------------------------------------------
`default_nettype none

package hra_pkg;

	// ring of accepted rates
	localparam int RING_DEPTH = 8;
	localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int RATE_W     = 8;
	localparam int SUM_W      = RATE_W + IDX_W;

	// floor(sum / RING_DEPTH) as a multiply by a rounded-up reciprocal
	localparam int AVG_SH    = SUM_W + IDX_W;
	localparam int RECIP_W   = SUM_W + 2;
	localparam int PROD_W    = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] AVG_RECIP =
		RECIP_W'(((64'd1 << AVG_SH) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH));

	// field widths
	localparam int LEVEL_W    = 18;
	localparam int TIME_W     = 32;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;

	// 60000 ms per minute, divided by the beat interval
	localparam int NUMER_W   = 16;
	localparam int QUOT_W    = NUMER_W;
	localparam int DIV_CNT_W = $clog2(NUMER_W);
	localparam logic [NUMER_W-1:0] RATE_NUMER = 16'd60000;

	// register reset values
	localparam logic [LEVEL_W-1:0] CONTACT_RST = 18'd50000;
	localparam logic [RATE_W-1:0]  LOW_RST     = 8'd60;
	localparam logic [RATE_W-1:0]  HIGH_RST    = 8'd100;
	localparam logic [RATE_W-1:0]  MIN_RST     = 8'd20;
	localparam logic [RATE_W-1:0]  MAX_RST     = 8'd220;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CONTACT_LEVEL = 3'd0,
		REG_LOW_LIMIT     = 3'd1,
		REG_HIGH_LIMIT    = 3'd2,
		REG_MIN_RATE      = 3'd3,
		REG_MAX_RATE      = 3'd4
	} hra_reg_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_WAIT   = 2'd0,
		STAT_LOW    = 2'd1,
		STAT_NORMAL = 2'd2,
		STAT_HIGH   = 2'd3
	} hra_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_AVG,
		ST_FIN
	} hra_state_t;

	typedef struct packed {
		logic              start;
		logic [TIME_W-1:0] divisor;
	} hra_div_req_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
		logic              rem_nz;
	} hra_div_res_t;

endpackage

`default_nettype wire

>>> rtl/hra_in_if.sv
// ----------------------------------------------------------------------------
// hra_in_if
// sample channel: sensor level, beat flag and millisecond time
// ----------------------------------------------------------------------------
`default_nettype none

interface hra_in_if;
	logic                         valid;
	logic                         ready;
	logic [hra_pkg::LEVEL_W-1:0]  sample_level;
	logic                         beat_seen;
	logic [hra_pkg::TIME_W-1:0]   now_ms;

	modport source (output valid, sample_level, beat_seen, now_ms, input ready);
	modport sink   (input valid, sample_level, beat_seen, now_ms, output ready);
endinterface

`default_nettype wire

>>> rtl/hra_out_if.sv
// ----------------------------------------------------------------------------
// hra_out_if
// result channel: average, instant rate, accept flag and status
// ----------------------------------------------------------------------------
`default_nettype none

interface hra_out_if;
	logic                          valid;
	logic                          ready;
	logic [hra_pkg::RATE_W-1:0]    average_rate;
	logic [hra_pkg::RATE_W-1:0]    instant_rate;
	logic                          rate_accepted;
	logic [hra_pkg::STATUS_W-1:0]  status;

	modport source (output valid, average_rate, instant_rate, rate_accepted, status,
		input ready);
	modport sink   (input valid, average_rate, instant_rate, rate_accepted, status,
		output ready);
endinterface

`default_nettype wire

>>> rtl/hra_ram.sv
// ----------------------------------------------------------------------------
// hra_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module hra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> rtl/hra_div.sv
// ----------------------------------------------------------------------------
// hra_div
// restoring divider, 60000 by a 32-bit interval, one quotient bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module hra_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hra_pkg::hra_div_req_t req,
	output hra_pkg::hra_div_res_t res
);

	logic                            busy_q;
	logic                            done_q;
	logic [hra_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [hra_pkg::TIME_W-1:0]      rem_q;
	logic [hra_pkg::TIME_W-1:0]      dvs_q;
	logic [hra_pkg::QUOT_W-1:0]      quot_q;
	logic [hra_pkg::TIME_W:0]        rem_sh;
	logic [hra_pkg::TIME_W:0]        rem_sub;
	logic                            fits;

	// shift in the next dividend bit, msb first
	assign rem_sh  = {rem_q, hra_pkg::RATE_NUMER[cnt_q]};
	assign fits    = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= hra_pkg::DIV_CNT_W'(hra_pkg::NUMER_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			quot_q <= '0;
			dvs_q  <= req.divisor;
		end else if (busy_q) begin
			rem_q  <= fits ? rem_sub[hra_pkg::TIME_W-1:0] : rem_sh[hra_pkg::TIME_W-1:0];
			quot_q <= {quot_q[hra_pkg::QUOT_W-2:0], fits};
		end
	end

	assign res.done   = done_q;
	assign res.quot   = quot_q;
	assign res.rem_nz = |rem_q;

endmodule

`default_nettype wire

>>> rtl/heart_rate_averager_alert_core.sv
// ----------------------------------------------------------------------------
// heart_rate_averager_alert_core
// pulse rate from beat intervals, averaged over a ring of accepted rates,
// with low / normal / high status
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake       word
//  sample    in    valid / ready   sample_level, beat_seen, now_ms
//  result    out   valid / ready   average_rate, instant_rate, rate_accepted,
//                                  status
//  cfg       in    cfg_wr_en       cfg_index, cfg_data (no read-back)
//
//  one sample at a time; an accepted beat goes from the accepting edge to the
//  result register load through capture, the bit-serial divider, the ring
//  update, the reciprocal multiply for the average and the hand-over; a beat
//  outside the rate window skips the average step
//  a word with no contact, no beat or a zero interval goes from capture
//  straight to the hand-over
//  the result register lets the next word in while a result waits; a stalled
//  result only holds the core in its hand-over step
//  asynchronous active-low reset; ring entries read as zero until first
//  written (one valid flop per entry), so no clearing pass is needed
//
`default_nettype none

module heart_rate_averager_alert_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [hra_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hra_pkg::CFG_DATA_W-1:0] cfg_data,
	hra_in_if.sink                         sample,
	hra_out_if.source                      result
);

	// status from the average, waiting has priority
	function automatic hra_pkg::hra_status_t status_of(
		input logic [hra_pkg::RATE_W-1:0] avg,
		input logic [hra_pkg::RATE_W-1:0] lo,
		input logic [hra_pkg::RATE_W-1:0] hi
	);
		hra_pkg::hra_status_t st;
		if (avg == '0) begin
			st = hra_pkg::STAT_WAIT;
		end else if (avg < lo) begin
			st = hra_pkg::STAT_LOW;
		end else if (avg > hi) begin
			st = hra_pkg::STAT_HIGH;
		end else begin
			st = hra_pkg::STAT_NORMAL;
		end
		return st;
	endfunction

	// configuration registers
	logic [hra_pkg::LEVEL_W-1:0]   contact_level_q;
	logic [hra_pkg::RATE_W-1:0]    low_limit_q;
	logic [hra_pkg::RATE_W-1:0]    high_limit_q;
	logic [hra_pkg::RATE_W-1:0]    min_rate_q;
	logic [hra_pkg::RATE_W-1:0]    max_rate_q;

	// sequencer
	hra_pkg::hra_state_t           state_q;
	hra_pkg::hra_state_t           state_d;

	// averaging state
	logic [hra_pkg::IDX_W-1:0]     slot_q;
	logic [hra_pkg::RING_DEPTH-1:0] ring_vld_q;
	logic [hra_pkg::TIME_W-1:0]    last_beat_q;
	logic [hra_pkg::RATE_W-1:0]    avg_q;
	logic [hra_pkg::SUM_W-1:0]     sum_q;

	// result being built
	logic [hra_pkg::RATE_W-1:0]    pend_inst_q;
	logic                          pend_acc_q;

	// output register
	logic                          out_valid_q;
	logic [hra_pkg::RATE_W-1:0]    out_avg_q;
	logic [hra_pkg::RATE_W-1:0]    out_inst_q;
	logic                          out_acc_q;
	hra_pkg::hra_status_t          out_status_q;

	// datapath
	logic                          in_acc;
	logic                          contact;
	logic [hra_pkg::TIME_W-1:0]    delta;
	hra_pkg::hra_div_req_t         div_req;
	hra_pkg::hra_div_res_t         div_res;
	logic                          above;
	logic                          below;
	logic                          rate_ok;
	logic                          upd;
	logic [hra_pkg::RATE_W-1:0]    inst_sat;
	logic [hra_pkg::RATE_W-1:0]    ram_rdata;
	logic [hra_pkg::RATE_W-1:0]    old_rate;
	logic [hra_pkg::SUM_W-1:0]     sum_nx;
	logic [hra_pkg::IDX_W-1:0]     slot_nx;
	logic [hra_pkg::PROD_W-1:0]    avg_prod;
	logic                          out_load;

	assign in_acc  = sample.valid && sample.ready;
	assign contact = sample.sample_level >= contact_level_q;
	assign delta   = sample.now_ms - last_beat_q;

	// start the divide only for a beat with contact and a non-zero interval
	assign div_req.start   = in_acc && contact && sample.beat_seen && (delta != '0);
	assign div_req.divisor = delta;

	hra_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

	// exact acceptance: the remainder breaks a tie at the lower limit
	assign above = (div_res.quot > hra_pkg::QUOT_W'(min_rate_q))
		|| ((div_res.quot == hra_pkg::QUOT_W'(min_rate_q)) && div_res.rem_nz);
	assign below    = div_res.quot < hra_pkg::QUOT_W'(max_rate_q);
	assign rate_ok  = above && below;
	assign inst_sat = (|div_res.quot[hra_pkg::QUOT_W-1:hra_pkg::RATE_W])
		? {hra_pkg::RATE_W{1'b1}} : div_res.quot[hra_pkg::RATE_W-1:0];

	// ring write when the quotient lands and passes the limits
	assign upd = (state_q == hra_pkg::ST_DIV) && div_res.done && rate_ok;

	// read port sits on the current slot; the slot moves only on a write and the
	// next write waits for a whole divide, so the old entry is ready before it is overwritten
	hra_ram #(
		.WIDTH (hra_pkg::RATE_W),
		.DEPTH (hra_pkg::RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (upd),
		.waddr (slot_q),
		.wdata (div_res.quot[hra_pkg::RATE_W-1:0]),
		.raddr (slot_q),
		.rdata (ram_rdata)
	);

	// never-written entries count as zero
	assign old_rate = ring_vld_q[slot_q] ? ram_rdata : '0;
	assign sum_nx   = sum_q - hra_pkg::SUM_W'(old_rate)
		+ hra_pkg::SUM_W'(div_res.quot[hra_pkg::RATE_W-1:0]);
	assign slot_nx  = (slot_q == hra_pkg::IDX_W'(hra_pkg::RING_DEPTH - 1))
		? '0 : slot_q + hra_pkg::IDX_W'(1);

	// floor of the running sum over the depth
	assign avg_prod = hra_pkg::PROD_W'(sum_q) * hra_pkg::PROD_W'(hra_pkg::AVG_RECIP);

	// result register takes the word when it is free or being emptied
	assign out_load = (state_q == hra_pkg::ST_FIN) && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hra_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			hra_pkg::ST_IDLE: begin
				if (in_acc) begin
					state_d = div_req.start ? hra_pkg::ST_DIV : hra_pkg::ST_FIN;
				end
			end
			hra_pkg::ST_DIV: begin
				if (div_res.done) begin
					state_d = rate_ok ? hra_pkg::ST_AVG : hra_pkg::ST_FIN;
				end
			end
			hra_pkg::ST_AVG: begin
				state_d = hra_pkg::ST_FIN;
			end
			hra_pkg::ST_FIN: begin
				if (out_load) begin
					state_d = hra_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = hra_pkg::ST_IDLE;
			end
		endcase
	end

	// configuration writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			contact_level_q <= hra_pkg::CONTACT_RST;
			low_limit_q     <= hra_pkg::LOW_RST;
			high_limit_q    <= hra_pkg::HIGH_RST;
			min_rate_q      <= hra_pkg::MIN_RST;
			max_rate_q      <= hra_pkg::MAX_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				hra_pkg::REG_CONTACT_LEVEL: contact_level_q <= cfg_data;
				hra_pkg::REG_LOW_LIMIT:     low_limit_q  <= cfg_data[hra_pkg::RATE_W-1:0];
				hra_pkg::REG_HIGH_LIMIT:    high_limit_q <= cfg_data[hra_pkg::RATE_W-1:0];
				hra_pkg::REG_MIN_RATE:      min_rate_q   <= cfg_data[hra_pkg::RATE_W-1:0];
				hra_pkg::REG_MAX_RATE:      max_rate_q   <= cfg_data[hra_pkg::RATE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// ring bookkeeping, last beat time and average
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			ring_vld_q  <= '0;
			last_beat_q <= '0;
			avg_q       <= '0;
			sum_q       <= '0;
		end else begin
			if (in_acc) begin
				if (!contact) begin
					// finger off: average cleared, ring kept
					avg_q <= '0;
				end else if (sample.beat_seen) begin
					// rejected beats still move the reference time
					last_beat_q <= sample.now_ms;
				end
			end
			if (upd) begin
				ring_vld_q[slot_q] <= 1'b1;
				slot_q             <= slot_nx;
				sum_q              <= sum_nx;
			end
			if (state_q == hra_pkg::ST_AVG) begin
				avg_q <= avg_prod[hra_pkg::AVG_SH +: hra_pkg::RATE_W];
			end
		end
	end

	// pending result fields
	always_ff @(posedge clk) begin
		if (in_acc) begin
			// same-ms beat counts as an infinite rate
			pend_inst_q <= (contact && sample.beat_seen && (delta == '0))
				? {hra_pkg::RATE_W{1'b1}} : '0;
			pend_acc_q  <= 1'b0;
		end else if ((state_q == hra_pkg::ST_DIV) && div_res.done) begin
			pend_inst_q <= inst_sat;
			pend_acc_q  <= rate_ok;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_avg_q    <= avg_q;
			out_inst_q   <= pend_inst_q;
			out_acc_q    <= pend_acc_q;
			out_status_q <= status_of(avg_q, low_limit_q, high_limit_q);
		end
	end

	assign sample.ready         = (state_q == hra_pkg::ST_IDLE);
	assign result.valid         = out_valid_q;
	assign result.average_rate  = out_avg_q;
	assign result.instant_rate  = out_inst_q;
	assign result.rate_accepted = out_acc_q;
	assign result.status        = out_status_q;

endmodule

`default_nettype wire

>>> rtl/hra_chk.sv
// ----------------------------------------------------------------------------
// hra_chk
// port-level checks on the pulse rate averager, bound to the core
// ----------------------------------------------------------------------------
`default_nettype none

`include "heart_rate_averager_alert_core_assert.svh"

module hra_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [hra_pkg::RATE_W-1:0]    out_average_rate,
	input logic [hra_pkg::RATE_W-1:0]    out_instant_rate,
	input logic                          out_rate_accepted,
	input logic [hra_pkg::STATUS_W-1:0]  out_status
);

	// a stalled result word holds
	`HRA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_average_rate) && $stable(out_instant_rate) && $stable(out_rate_accepted) && $stable(out_status), "stalled result word changed")

	// one word in flight: ready drops after every acceptance
	`HRA_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second word taken while busy")

	// waiting status exactly when there is no average
	`HRA_ASSERT(a_wait_status, out_valid |-> ((out_average_rate == '0) == (out_status == hra_pkg::STAT_WAIT)), "status disagrees with average")

	// an accepted rate sits below the maximum, so it never saturates
	`HRA_ASSERT(a_acc_range, (out_valid && out_rate_accepted) |-> (out_instant_rate != '1), "accepted rate out of range")

endmodule

bind heart_rate_averager_alert_core hra_chk u_hra_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (sample.valid),
	.in_ready          (sample.ready),
	.out_valid         (result.valid),
	.out_ready         (result.ready),
	.out_average_rate  (result.average_rate),
	.out_instant_rate  (result.instant_rate),
	.out_rate_accepted (result.rate_accepted),
	.out_status        (result.status)
);

`default_nettype wire

>>> sim/heart_rate_averager_alert_core_test.sv
// ----------------------------------------------------------------------------
// heart_rate_averager_alert_core_test
// self-checking bench for the pulse rate averager: a table of directed sample
// words, then runs of paced beats mixed with noise, under several register
// settings and three handshake pacing modes, each result word checked
// against its typed result or a predictor of the ring, average and status
// ----------------------------------------------------------------------------
`default_nettype none

module heart_rate_averager_alert_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import hra_pkg::*;

	// one result word as the predictor builds it
	typedef struct packed {
		logic [RATE_W-1:0] average;
		logic [RATE_W-1:0] instant;
		logic              accepted;
		hra_status_t       status;
	} pulse_word_t;

	// one row of the directed table; typed rows carry their own result
	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               beat;
		logic [TIME_W-1:0]  now;
		logic               typed;
		pulse_word_t        want;
	} sample_row_t;

	localparam logic [31:0] MS_PER_MINUTE = 32'd60000;
	localparam int          SETTLE_CYCLES = 24;
	localparam int          RANDOM_WORDS  = 1300;
	localparam int          PHASES        = 6;
	localparam int          DIRECTED_ROWS = 23;

	// all-zero result: no contact, or contact with nothing averaged yet
	localparam pulse_word_t QUIET_WORD = '{8'd0, 8'd0, 1'b0, STAT_WAIT};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	hra_in_if  sample_if();
	hra_out_if result_if();

	heart_rate_averager_alert_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_if),
		.result    (result_if)
	);

	// predictor copy of the registers
	logic [LEVEL_W-1:0] contact_lvl;
	logic [RATE_W-1:0]  low_lim;
	logic [RATE_W-1:0]  high_lim;
	logic [RATE_W-1:0]  min_bpm;
	logic [RATE_W-1:0]  max_bpm;

	// predictor copy of the ring and timing state
	logic [RATE_W-1:0]  bpm_ring [RING_DEPTH];
	int unsigned        ring_slot;
	logic [TIME_W-1:0]  last_beat_ms;
	logic [RATE_W-1:0]  avg_bpm;

	pulse_word_t pending_words [$];
	int          mismatch_count;
	int          in_idle_pct;
	int          out_idle_pct;

	// directed words, starting from the reset settings
	sample_row_t directed_rows [DIRECTED_ROWS] = '{
		// no contact at the lowest level, beat ignored
		'{18'd0,      1'b1, 32'd1000,       1'b1, QUIET_WORD},
		// one below the contact level
		'{18'd49999,  1'b1, 32'd0,          1'b1, QUIET_WORD},
		// contact exactly at the level, no beat, nothing averaged yet
		'{18'd50000,  1'b0, 32'd500,        1'b1, QUIET_WORD},
		// first beat, measured from time zero: 60 bpm
		'{18'd262143, 1'b1, 32'd1000,       1'b0, QUIET_WORD},
		// same millisecond again: infinite rate, saturated and rejected
		'{18'd80000,  1'b1, 32'd1000,       1'b0, QUIET_WORD},
		// exactly the minimum rate is rejected
		'{18'd80000,  1'b1, 32'd4000,       1'b0, QUIET_WORD},
		// just above the minimum by a remainder is taken
		'{18'd80000,  1'b1, 32'd6999,       1'b0, QUIET_WORD},
		// 219 bpm, just under the maximum
		'{18'd80000,  1'b1, 32'd7272,       1'b0, QUIET_WORD},
		// 220 bpm equals the maximum, rejected
		'{18'd80000,  1'b1, 32'd7544,       1'b0, QUIET_WORD},
		// one millisecond apart: instant rate saturates
		'{18'd80000,  1'b1, 32'd7545,       1'b0, QUIET_WORD},
		// huge gap, rate rounds to zero
		'{18'd80000,  1'b1, 32'hFFFF_FF00,  1'b0, QUIET_WORD},
		// timestamp wraps, 512 ms gap
		'{18'd80000,  1'b1, 32'h0000_0100,  1'b0, QUIET_WORD},
		// eight beats at 100 bpm fill the ring: average on the high limit
		'{18'd90000,  1'b1, 32'd856,        1'b0, QUIET_WORD},
		'{18'd90000,  1'b1, 32'd1456,       1'b0, QUIET_WORD},
		'{18'd90000,  1'b1, 32'd2056,       1'b0, QUIET_WORD},
		'{18'd90000,  1'b1, 32'd2656,       1'b0, QUIET_WORD},
		'{18'd90000,  1'b1, 32'd3256,       1'b0, QUIET_WORD},
		'{18'd90000,  1'b1, 32'd3856,       1'b0, QUIET_WORD},
		'{18'd90000,  1'b1, 32'd4456,       1'b0, QUIET_WORD},
		'{18'd90000,  1'b1, 32'd5056,       1'b0, QUIET_WORD},
		// finger lifted: average cleared
		'{18'd49999,  1'b0, 32'd5100,       1'b1, QUIET_WORD},
		// back in contact at the top timestamp, still waiting
		'{18'd50000,  1'b0, 32'hFFFF_FFFF,  1'b1, QUIET_WORD},
		// next beat rebuilds the average from the kept ring
		'{18'd200000, 1'b1, 32'd5656,       1'b0, QUIET_WORD}
	};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit, well beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("[heart_rate_averager_alert_core] ERROR");
		$finish;
	end

	function automatic hra_status_t status_for(input logic [RATE_W-1:0] avg);
		if (avg == 0)
			return STAT_WAIT;
		if (avg < low_lim)
			return STAT_LOW;
		if (avg > high_lim)
			return STAT_HIGH;
		return STAT_NORMAL;
	endfunction

	// advance the predicted state by one accepted word and build its result
	function automatic pulse_word_t pulse_predict(input logic [LEVEL_W-1:0] level,
		input logic beat, input logic [TIME_W-1:0] now);
		logic [31:0] gap;
		logic [31:0] quot;
		logic [31:0] rem;
		int unsigned sum;
		pulse_word_t w;

		w = QUIET_WORD;
		// no contact: only the average is touched
		if (level < contact_lvl) begin
			avg_bpm = '0;
			return w;
		end
		if (beat) begin
			gap = now - last_beat_ms;
			last_beat_ms = now;
			if (gap == 0) begin
				w.instant = 8'd255;
			end else begin
				quot = MS_PER_MINUTE / gap;
				rem  = MS_PER_MINUTE % gap;
				w.instant = (quot > 255) ? 8'd255 : quot[RATE_W-1:0];
				// exact rational bounds: a remainder lifts a quotient equal to the minimum
				if ((quot > min_bpm || (quot == min_bpm && rem != 0)) && quot < max_bpm) begin
					bpm_ring[ring_slot] = quot[RATE_W-1:0];
					ring_slot = (ring_slot + 1) % RING_DEPTH;
					sum = 0;
					for (int i = 0; i < RING_DEPTH; i++)
						sum += bpm_ring[i];
					avg_bpm = RATE_W'(sum / RING_DEPTH);
					w.accepted = 1'b1;
				end
			end
		end
		w.average = avg_bpm;
		w.status  = status_for(avg_bpm);
		return w;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// register write, one per clock; the caller drops the enable after the last
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_CONTACT_LEVEL: contact_lvl = data;
			REG_LOW_LIMIT:     low_lim     = data[RATE_W-1:0];
			REG_HIGH_LIMIT:    high_lim    = data[RATE_W-1:0];
			REG_MIN_RATE:      min_bpm     = data[RATE_W-1:0];
			REG_MAX_RATE:      max_bpm     = data[RATE_W-1:0];
			default: ;
		endcase
	endtask

	// hold the sample channel until every word is back and the core has settled,
	// then rewrite the registers
	task automatic set_limits(input logic [CFG_DATA_W-1:0] contact,
		input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
		input logic [CFG_DATA_W-1:0] mn, input logic [CFG_DATA_W-1:0] mx,
		input logic with_unused);
		sample_if.valid <= 1'b0;
		wait (pending_words.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_write(REG_CONTACT_LEVEL, contact);
		cfg_write(REG_LOW_LIMIT, lo);
		cfg_write(REG_HIGH_LIMIT, hi);
		cfg_write(REG_MIN_RATE, mn);
		cfg_write(REG_MAX_RATE, mx);
		// indexes past the last register must change nothing
		if (with_unused)
			for (int i = REG_MAX_RATE + 1; i < (1 << CFG_IDX_W); i++)
				cfg_write(CFG_IDX_W'(i), CFG_DATA_W'($urandom()));
		cfg_wr_en <= 1'b0;
	endtask

	// offer one sample word, with a random gap in front, and log its result
	task automatic send_sample(input logic [LEVEL_W-1:0] level, input logic beat,
		input logic [TIME_W-1:0] now, input logic typed, input pulse_word_t want);
		pulse_word_t guess;
		logic        took;

		if (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
			sample_if.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < in_idle_pct);
		end
		sample_if.valid        <= 1'b1;
		sample_if.sample_level <= level;
		sample_if.beat_seen    <= beat;
		sample_if.now_ms       <= now;
		// ready only moves on a rising edge, so look at it on the falling edge before
		do begin
			@(negedge clk);
			took = sample_if.ready;
			@(posedge clk);
		end while (!took);
		guess = pulse_predict(level, beat, now);
		pending_words.push_back(typed ? want : guess);
	endtask

	function automatic logic [LEVEL_W-1:0] touching_level();
		return LEVEL_W'($urandom_range(18'h3FFFF, contact_lvl));
	endfunction

	// beat interval: mostly plausible pulses, some fast, some on the limits
	function automatic logic [31:0] pick_gap();
		int unsigned roll;
		int unsigned bound_rate;

		roll = $urandom_range(99);
		if (roll < 55)
			return $urandom_range(3000, 272);
		if (roll < 70)
			return $urandom_range(300, 1);
		if (roll < 85) begin
			case ($urandom_range(3))
				0:       bound_rate = min_bpm;
				1:       bound_rate = max_bpm;
				2:       bound_rate = low_lim;
				default: bound_rate = high_lim;
			endcase
			if (bound_rate == 0)
				return $urandom_range(200000, 60001);
			return MS_PER_MINUTE / bound_rate + $urandom_range(2) - 1;
		end
		if (roll < 95)
			return $urandom_range(70000, 3000);
		return $urandom();
	endfunction

	// runs of steady beats with contact, broken up by lifts, repeats and noise
	task automatic run_random(input int count);
		int unsigned       run_left;
		int unsigned       roll;
		logic [31:0]       run_gap;
		logic [TIME_W-1:0] ms_now;
		logic [TIME_W-1:0] stamp;
		logic [LEVEL_W-1:0] level;
		logic              beat;

		run_left = 0;
		run_gap  = 32'd1000;
		ms_now   = last_beat_ms;
		repeat (count) begin
			if (run_left == 0) begin
				run_left = $urandom_range(16, 4);
				run_gap  = pick_gap();
			end
			run_left--;
			roll  = $urandom_range(99);
			level = touching_level();
			beat  = 1'b1;
			stamp = last_beat_ms + run_gap + (($urandom_range(3) == 0) ? $urandom_range(2) : 0);
			if (roll < 6) begin
				// finger lifted
				level = (contact_lvl == 0) ? LEVEL_W'($urandom())
					: LEVEL_W'($urandom_range(contact_lvl - 1, 0));
				beat  = 1'($urandom_range(1));
				stamp = ms_now + $urandom_range(40);
			end else if (roll < 12) begin
				// anything at all
				level = LEVEL_W'($urandom());
				beat  = 1'($urandom_range(1));
				stamp = $urandom();
			end else if (roll < 16) begin
				// second beat in the same millisecond
				stamp = last_beat_ms;
			end else if (roll < 28) begin
				// sample between beats
				beat  = 1'b0;
				stamp = ms_now + $urandom_range(40);
			end else if (roll < 36) begin
				// stray beat off the run's pace
				stamp = last_beat_ms + pick_gap();
			end
			ms_now = stamp;
			send_sample(level, beat, stamp, 1'b0, QUIET_WORD);
		end
	endtask

	// result side: random back-pressure, every word checked against the oldest
	// expectation; the handshake is read on the falling edge ahead of its rising
	// edge, where valid, ready and the word are all steady
	initial begin
		result_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (arst_n && result_if.valid && result_if.ready) begin
				if (pending_words.size() == 0) begin
					report_mismatch($sformatf("word with none expected: avg %0d inst %0d",
						result_if.average_rate, result_if.instant_rate));
				end else begin
					automatic pulse_word_t want = pending_words.pop_front();
					if (result_if.average_rate !== want.average)
						report_mismatch($sformatf("average_rate %0d, expected %0d",
							result_if.average_rate, want.average));
					if (result_if.instant_rate !== want.instant)
						report_mismatch($sformatf("instant_rate %0d, expected %0d",
							result_if.instant_rate, want.instant));
					if (result_if.rate_accepted !== want.accepted)
						report_mismatch($sformatf("rate_accepted %0b, expected %0b",
							result_if.rate_accepted, want.accepted));
					if (result_if.status !== want.status)
						report_mismatch($sformatf("status %0d, expected %s",
							result_if.status, want.status.name()));
				end
			end
			@(posedge clk);
			result_if.ready <= ($urandom_range(99) >= out_idle_pct);
		end
	end

	// sample side and overall sequencing
	initial begin
		arst_n                 = 1'b0;
		cfg_wr_en              = 1'b0;
		cfg_index              = '0;
		cfg_data               = '0;
		sample_if.valid        = 1'b0;
		sample_if.sample_level = '0;
		sample_if.beat_seen    = 1'b0;
		sample_if.now_ms       = '0;
		mismatch_count         = 0;
		in_idle_pct            = 17;
		out_idle_pct           = 75;

		// predictor starts from the reset state
		contact_lvl  = 18'd50000;
		low_lim      = 8'd60;
		high_lim     = 8'd100;
		min_bpm      = 8'd20;
		max_bpm      = 8'd220;
		for (int i = 0; i < RING_DEPTH; i++)
			bpm_ring[i] = '0;
		ring_slot    = 0;
		last_beat_ms = '0;
		avg_bpm      = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_sample(directed_rows[i].level, directed_rows[i].beat,
				directed_rows[i].now, directed_rows[i].typed, directed_rows[i].want);

		for (int phase = 0; phase < PHASES; phase++) begin
			// pacing: slow receiver, then slow sender, then both flat out
			case (phase / 2)
				0: begin
					in_idle_pct  = 17;
					out_idle_pct = 75;
				end
				1: begin
					in_idle_pct  = 75;
					out_idle_pct = 17;
				end
				default: begin
					in_idle_pct  = 0;
					out_idle_pct = 0;
				end
			endcase
			case (phase)
				// everything in contact, widest acceptance, no alert possible
				1: set_limits(18'd0, 18'd0, 18'd255, 18'd0, 18'd255, 1'b0);
				// only the top level in contact, one-bpm-wide window
				2: set_limits(18'h3FFFF, 18'd255, 18'd0, 18'd254, 18'd255, 1'b0);
				// inverted rate window, upper data bits set on the narrow registers
				3: set_limits(18'd1000, 18'h3FF00 | 18'd80, 18'h2A400 | 18'd120,
					18'h15600 | 18'd150, 18'h3FF00 | 18'd100, 1'b1);
				4: set_limits(18'd120000, 18'd70, 18'd90, 18'd40, 18'd180, 1'b0);
				// back to the power-up values
				5: set_limits(18'd50000, 18'd60, 18'd100, 18'd20, 18'd220, 1'b0);
				default: ;
			endcase
			run_random(RANDOM_WORDS / PHASES);
		end

		sample_if.valid <= 1'b0;
		wait (pending_words.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_words.size() == 0)
			$display("[heart_rate_averager_alert_core] OK");
		else
			$display("[heart_rate_averager_alert_core] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
